// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mbp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types and constants of the MSB-first bit packer.
// ----------------------------------------------------------------------------
package mbp_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned TDATA_W = 40;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic               eos;
    logic               bad;
  } item_t;

endpackage

// ===== design/mbp_front.sv =====
// ----------------------------------------------------------------------------
// mbp_front
// Unpacks an input word, saturates the bit count and flags stray high bits.
// ----------------------------------------------------------------------------
module mbp_front import mbp_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic [TDATA_W-1:0] s_tdata,   // value[31:0], count[37:32], zero pad
  input  logic               s_tlast,   // end of stream
  output item_t              item
);

  localparam int unsigned LIMIT = (WORD_BITS < VALUE_W) ? WORD_BITS : VALUE_W;

  logic [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] count_in;
  logic [COUNT_W-1:0] count_sat;

  assign value    = s_tdata[VALUE_W-1:0];
  assign count_in = s_tdata[VALUE_W+COUNT_W-1:VALUE_W];

  always_comb begin
    count_sat  = (count_in > COUNT_W'(LIMIT)) ? COUNT_W'(LIMIT) : count_in;
    item.value = value;
    item.count = count_sat;
    item.eos   = s_tlast;
    item.bad   = (count_sat < COUNT_W'(VALUE_W)) && ((value >> count_sat) != '0);
  end

endmodule

// ===== design/mbp_queue.sv =====
// ----------------------------------------------------------------------------
// mbp_queue
// Two-entry queue of classified items between front and back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbp_queue import mbp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t       entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  `ASSERT_ALWAYS(a_count_range, count != 2'd3, "queue count out of range")
  `ASSERT_ALWAYS(a_no_pop_empty, !pop || head_valid, "pop from empty queue")
  `ASSERT_NEXT(a_push_seen, do_push && !do_pop, head_valid, "pushed item not visible")

endmodule

// ===== design/mbp_back.sv =====
// ----------------------------------------------------------------------------
// mbp_back
// Packing engine: merges codes into the partial word, emits full and
// flushed words and rejected-input results through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbp_back import mbp_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  item_t              head_item,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // word[31:0], fill_bits[37:32], zero pad
  output logic               m_tuser,   // bad_input
  output logic               m_tlast
);

  localparam int unsigned FILL_W = $clog2(WORD_BITS);
  localparam int unsigned SUM_W  = $clog2(2 * WORD_BITS);
  localparam int unsigned EXT_W  = WORD_BITS + VALUE_W;

  logic [WORD_BITS-1:0] partial_word;
  logic [FILL_W-1:0]    fill_count;
  logic                 phase;

  logic [WORD_BITS-1:0] partial_word_next;
  logic [FILL_W-1:0]    fill_count_next;
  logic                 phase_next;

  logic [VALUE_W-1:0]   out_word;
  logic [COUNT_W-1:0]   out_fill;
  logic                 out_bad;
  logic                 out_last;

  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     over;
  logic [EXT_W-1:0]     value_ext;
  logic [EXT_W-1:0]     shl_lo;
  logic [EXT_W-1:0]     shl_hi;
  logic [EXT_W-1:0]     shr_full;
  logic [EXT_W-1:0]     word_ext;
  logic                 has_full;
  logic                 has_flush;
  logic [WORD_BITS-1:0] pack_word;
  logic [FILL_W-1:0]    pack_fill;
  logic [WORD_BITS-1:0] full_word;
  logic                 emit;
  logic                 can_load;
  logic                 go;
  logic [WORD_BITS-1:0] sel_word;
  logic [COUNT_W-1:0]   sel_fill;
  logic                 sel_bad;
  logic                 sel_last;

  assign can_load  = !m_tvalid || m_tready;
  assign value_ext = EXT_W'(head_item.value);
  assign sum       = SUM_W'(fill_count) + SUM_W'(head_item.count);
  assign has_full  = (sum >= SUM_W'(WORD_BITS));
  assign over      = sum - SUM_W'(WORD_BITS);
  assign shl_lo    = value_ext << (SUM_W'(WORD_BITS) - sum);
  assign shl_hi    = value_ext << (SUM_W'(WORD_BITS) - over);
  assign shr_full  = value_ext >> over;
  assign full_word = partial_word | shr_full[WORD_BITS-1:0];

  always_comb begin
    if (has_full) begin
      pack_word = shl_hi[WORD_BITS-1:0];
      pack_fill = FILL_W'(over);
    end else begin
      pack_word = partial_word | shl_lo[WORD_BITS-1:0];
      pack_fill = FILL_W'(sum);
    end
    has_flush = head_item.eos && (pack_fill != '0);

    emit              = phase || head_item.bad || has_full || has_flush;
    go                = head_valid && (!emit || can_load);
    partial_word_next = partial_word;
    fill_count_next   = fill_count;
    phase_next        = phase;
    pop               = go;
    sel_word          = '0;
    sel_fill          = '0;
    sel_bad           = 1'b0;
    sel_last          = 1'b1;

    if (phase) begin
      sel_word          = partial_word;
      sel_fill          = COUNT_W'(fill_count);
      partial_word_next = '0;
      fill_count_next   = '0;
      phase_next        = 1'b0;
    end else if (head_item.bad) begin
      sel_bad = 1'b1;
    end else if (has_full) begin
      sel_word          = full_word;
      sel_fill          = COUNT_W'(WORD_BITS);
      sel_last          = !has_flush;
      partial_word_next = pack_word;
      fill_count_next   = pack_fill;
      if (has_flush) begin
        phase_next = 1'b1;
        pop        = 1'b0;
      end
    end else if (has_flush) begin
      sel_word          = pack_word;
      sel_fill          = COUNT_W'(pack_fill);
      partial_word_next = '0;
      fill_count_next   = '0;
    end else begin
      partial_word_next = pack_word;
      fill_count_next   = pack_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_word <= '0;
      fill_count   <= '0;
      phase        <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (go) begin
        partial_word <= partial_word_next;
        fill_count   <= fill_count_next;
        phase        <= phase_next;
      end
      if (can_load) begin
        m_tvalid <= head_valid && emit;
      end
    end
  end

  assign word_ext = EXT_W'(sel_word);

  always_ff @(posedge clk) begin
    if (can_load) begin
      out_word <= word_ext[VALUE_W-1:0];
      out_fill <= sel_fill;
      out_bad  <= sel_bad;
      out_last <= sel_last;
    end
  end

  assign m_tdata = {{(TDATA_W - VALUE_W - COUNT_W){1'b0}}, out_fill, out_word};
  assign m_tuser = out_bad;
  assign m_tlast = out_last;

  `ASSERT_ALWAYS(a_phase_has_item, !phase || head_valid, "flush phase without item")
  `ASSERT_ALWAYS(a_fill_below_word, fill_count < FILL_W'(WORD_BITS - 1) ||
                 fill_count == FILL_W'(WORD_BITS - 1), "fill count past word")
  `ASSERT_ALWAYS(a_bad_is_empty, !(m_tvalid && m_tuser) ||
                 (m_tlast && m_tdata == '0), "rejected result not empty")
  `ASSERT_NEXT(a_split_flush, go && !pop, phase, "second result not scheduled")

endmodule

// ===== design/msb_first_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// msb_first_bit_packer_unit
// MSB-first variable-length bit packer: appends codes to a stream of words
// filled from the top, emits full words and a flushed partial at stream end.
// ----------------------------------------------------------------------------
//   channel   dir  tdata                          tuser      tlast
//   s_*       in   value[31:0] count[37:32]       -          end of stream
//   m_*       out  word[31:0] fill_bits[37:32]    bad_input  last of item
//
// One code per cycle while results are accepted; an item giving a full word
// plus a flushed partial holds the packing engine for an extra flush phase.
// Each code passes through a queue entry; its results then pass through the output register.
// While m_tready is low the two-entry queue takes two more words that give
// results; words that give none keep passing through.
// rst is synchronous and clears the queue, pack state and output valid.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_unit import mbp_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // value[31:0], count[37:32], zero pad
  input  logic               s_tlast,   // end_of_stream
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // word[31:0], fill_bits[37:32], zero pad
  output logic               m_tuser,   // bad_input
  output logic               m_tlast    // last
);

  item_t in_item;
  item_t head_item;
  logic  full;
  logic  head_valid;
  logic  pop;

  mbp_front #(.WORD_BITS(WORD_BITS)) u_front (
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .item    (in_item)
  );

  mbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_tvalid),
    .push_item  (in_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  assign s_tready = !full;

  mbp_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

// ===== tb/packed_word_checker.sv =====
// ----------------------------------------------------------------------------
// packed_word_checker
// Watches both streams of the MSB-first bit packer. Every accepted code goes
// through a local packing model that queues the words it should produce. Each
// accepted output word is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packed_word_checker import mbp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // value[31:0], count[37:32], zero pad
  input  logic               s_tlast,   // end_of_stream
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [TDATA_W-1:0] m_tdata,   // word[31:0], fill_bits[37:32], zero pad
  input  logic               m_tuser,   // bad_input
  input  logic               m_tlast,   // last
  output int                 errors,
  output int                 words_due
);

  typedef struct packed {
    logic [31:0] word;
    logic [5:0]  fill_bits;
    logic        bad;
    logic        last;
  } packed_word_t;

  packed_word_t expected_words[$];
  logic [31:0]  acc_bits;
  int unsigned  acc_fill;

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic pack_code(input logic [31:0] value, input logic [5:0] count,
                           input logic eos);
    int unsigned  n;
    int unsigned  over;
    int           k;
    logic [63:0]  v64;
    packed_word_t outs [2];
    n = count;
    k = 0;
    v64 = {32'h0, value};
    if (n > 32) n = 32;
    if (n < 32 && (value >> n) != 0) begin
      outs[0].word = '0;
      outs[0].fill_bits = '0;
      outs[0].bad = 1'b1;
      outs[0].last = 1'b1;
      expected_words = {expected_words, outs[0]};
      return;
    end
    if (acc_fill + n < 32) begin
      acc_bits = acc_bits | 32'(v64 << (32 - acc_fill - n));
      acc_fill = acc_fill + n;
    end else begin
      over = acc_fill + n - 32;
      outs[k].word = acc_bits | 32'(v64 >> over);
      outs[k].fill_bits = 6'd32;
      outs[k].bad = 1'b0;
      outs[k].last = 1'b0;
      k++;
      acc_bits = (over > 0) ? 32'(v64 << (32 - over)) : 32'h0;
      acc_fill = over;
    end
    if (eos && acc_fill > 0) begin
      outs[k].word = acc_bits;
      outs[k].fill_bits = 6'(acc_fill);
      outs[k].bad = 1'b0;
      outs[k].last = 1'b0;
      k++;
      acc_bits = '0;
      acc_fill = 0;
    end
    if (k > 0) outs[k-1].last = 1'b1;
    for (int i = 0; i < k; i++) expected_words = {expected_words, outs[i]};
  endtask

  always @(posedge clk) begin
    packed_word_t got;
    packed_word_t want;
    if (rst) begin
      expected_words.delete();
      acc_bits = '0;
      acc_fill = 0;
      errors = 0;
    end else begin
      if (s_tvalid && s_tready) pack_code(s_tdata[31:0], s_tdata[37:32], s_tlast);
      if (m_tvalid && m_tready) begin
        got.word = m_tdata[31:0];
        got.fill_bits = m_tdata[37:32];
        got.bad = m_tuser;
        got.last = m_tlast;
        if (expected_words.size() == 0) begin
          note_error($sformatf("unexpected word %h fill %0d bad %b last %b",
                               got.word, got.fill_bits, got.bad, got.last));
        end else begin
          want = expected_words.pop_front();
          if (got.word !== want.word || got.fill_bits !== want.fill_bits ||
              got.bad !== want.bad || got.last !== want.last)
            note_error($sformatf(
              "word mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
              want.word, want.fill_bits, want.bad, want.last,
              got.word, got.fill_bits, got.bad, got.last));
        end
      end
    end
    words_due <= expected_words.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the MSB-first bit packer: directed codes around word
// boundaries, count saturation, rejected values and flushes, then random
// code streams under varying sender and receiver idling, a long output stall
// and a full drain. The checker beside the block gives the error count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import mbp_pkg::*; ();

  logic               clk = 1'b0;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata;    // value[31:0], count[37:32], zero pad
  logic               s_tlast;    // end_of_stream
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;    // word[31:0], fill_bits[37:32], zero pad
  logic               m_tuser;    // bad_input
  logic               m_tlast;    // last

  int errors;
  int words_due;
  bit s_idle;
  bit m_idle;
  bit hold_req;

  always #2 clk = ~clk;

  msb_first_bit_packer_unit #(.WORD_BITS(32)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  packed_word_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .errors(errors), .words_due(words_due)
  );

  task automatic send_code(input logic [31:0] value, input logic [5:0] count,
                           input logic eos);
    int gap;
    gap = s_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, count, value};
    s_tlast  <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random_code();
    int unsigned pick;
    int unsigned c;
    logic [31:0] v;
    logic        e;
    pick = $urandom_range(0, 99);
    e = ($urandom_range(0, 7) == 0);
    if (pick < 10) begin
      // value with a set bit above the count
      c = $urandom_range(0, 31);
      v = ($urandom & ((32'h1 << c) - 1)) | (32'h1 << $urandom_range(c, 31));
    end else if (pick < 16) begin
      c = $urandom_range(33, 63);
      v = $urandom;
    end else begin
      c = $urandom_range(0, 32);
      v = (c == 32) ? $urandom : ($urandom & ((32'h1 << c) - 1));
    end
    send_code(v, 6'(c), e);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  // output side
  initial begin
    int gap;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = m_idle ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    s_idle = 1'b0;
    m_idle = 1'b0;
    hold_req = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_code(32'hFFFF_FFFF, 6'd32, 1'b0);  // full word from an empty stream
    send_code(32'h0, 6'd0, 1'b1);           // flush with nothing gathered
    send_code(32'h1, 6'd1, 1'b0);
    send_code(32'h7FFF, 6'd15, 1'b0);
    send_code(32'hA5A5, 6'd16, 1'b0);       // fills the word exactly
    send_code(32'hDEAD_BEEF, 6'd32, 1'b0);  // starts on a word boundary
    send_code(32'h5, 6'd3, 1'b0);
    send_code(32'hFFFF_FFFF, 6'd63, 1'b0);  // count saturates
    send_code(32'h10, 6'd4, 1'b0);          // rejected
    send_code(32'h3, 6'd1, 1'b1);           // rejected, no flush
    send_code(32'h1_2345, 6'd20, 1'b1);
    send_code(32'h7, 6'd3, 1'b0);
    send_code(32'h8000_0000, 6'd32, 1'b1);  // full word plus flushed partial
    send_code(32'h0, 6'd40, 1'b0);
    send_code(32'h1, 6'd33, 1'b0);
    send_code(32'h0, 6'd0, 1'b1);           // flush only
    send_code(32'hFFFF_FFFF, 6'd31, 1'b0);  // rejected, top bit set
    send_code(32'h1, 6'd0, 1'b1);           // rejected with zero count
    send_code(32'h1, 6'd2, 1'b0);
    send_code(32'h0, 6'd0, 1'b0);

    for (int p = 0; p < 4; p++) begin
      s_idle = p[0];
      m_idle = p[1];
      repeat (340) send_random_code();
      if (p == 0) begin
        // stall the output while codes keep coming back to back
        hold_req = 1'b1;
        repeat (40) send_code($urandom, 6'd32, 1'b0);
      end
      if (p == 1) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && words_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
